>>> rtl/spq_pkg.sv
// spq_pkg: shared constants, codes and transaction types of the sorted priority queue
// used by every file under rtl, no dependencies of its own
package spq_pkg;

	localparam int unsigned QUEUE_DEPTH = 64;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned KEY_W = 16;
	localparam int unsigned ID_W = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [KEY_W-1:0]  entry_key;
		logic [ID_W-1:0]   entry_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   head_id;
		logic [KEY_W-1:0]  head_key;
		logic              head_valid;
		logic              queue_empty;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    exec;
		logic    shift_in;
		logic    shift_out;
		logic    head_load;
		status_t status;
	} ctrl_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
	} dp_stat_t;

endpackage

>>> rtl/spq_if.sv
// spq_if: valid/ready channel interfaces for request and response transactions
// depends on spq_pkg for the payload types
interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/spq_ctrl.sv
// spq_ctrl: two-state controller, sequences compare and shift steps and owns the result slot
// depends on spq_pkg for states, codes and the command/status structs
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  spq_pkg::dp_stat_t   stat,
	output spq_pkg::ctrl_cmd_t  cmd
);

	spq_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;
	logic            slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.status    = spq_pkg::ST_OK;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
				if (req_valid) begin
					state_d = spq_pkg::S_EXEC;
				end
			end
			spq_pkg::S_EXEC: begin
				if (slot_free) begin
					cmd.exec = 1'b1;
					state_d  = spq_pkg::S_IDLE;
					unique case (stat.op)
						spq_pkg::OP_INSERT: begin
							cmd.shift_in = !stat.full;
							cmd.status   = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
						end
						spq_pkg::OP_POP: begin
							cmd.shift_out = !stat.empty;
							cmd.head_load = !stat.empty;
							cmd.status    = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
						end
						spq_pkg::OP_PEEK: begin
							cmd.head_load = !stat.empty;
							cmd.status    = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
						end
						spq_pkg::OP_NOP: begin
							cmd.status = spq_pkg::ST_OK;
						end
						default: begin
							cmd.status = spq_pkg::ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.exec) begin
			out_valid_d = 1'b1;
		end else if (rsp_ready) begin
			out_valid_d = 1'b0;
		end
	end

endmodule

>>> rtl/spq_dp.sv
// spq_dp: compare-and-shift cell array, entry count and result register
// depends on spq_pkg for sizes and types, driven by spq_ctrl commands
module spq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::req_t       req_data,
	input  spq_pkg::ctrl_cmd_t  cmd,
	output spq_pkg::dp_stat_t   stat,
	output spq_pkg::rsp_t       rsp_data
);

	localparam int unsigned DEPTH = spq_pkg::QUEUE_DEPTH;
	localparam int unsigned CW    = spq_pkg::CNT_W;

	logic [spq_pkg::KEY_W-1:0] key_q [DEPTH];
	logic [spq_pkg::ID_W-1:0]  id_q [DEPTH];
	logic [DEPTH-1:0]          gt_q;
	logic [CW-1:0]             count_q, count_d;
	spq_pkg::opcode_t          op_q;
	logic [spq_pkg::KEY_W-1:0] nkey_q;
	logic [spq_pkg::ID_W-1:0]  nid_q;
	spq_pkg::rsp_t             rsp_q;

	// latch the request and compare it against every occupied cell
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_data.opcode;
			nkey_q <= req_data.entry_key;
			nid_q  <= req_data.entry_id;
			for (int i = 0; i < DEPTH; i++) begin
				gt_q[i] <= (CW'(i) < count_q) && (key_q[i] > req_data.entry_key);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int Prv = (i == 0) ? 0 : i - 1;
		localparam int Nxt = (i == DEPTH - 1) ? i : i + 1;
		logic prev_gt;
		assign prev_gt = (i != 0) && gt_q[Prv];

		always_ff @(posedge clk) begin
			if (cmd.shift_in) begin
				if (prev_gt) begin
					key_q[i] <= key_q[Prv];
					id_q[i]  <= id_q[Prv];
				end else if (gt_q[i] || (CW'(i) == count_q)) begin
					key_q[i] <= nkey_q;
					id_q[i]  <= nid_q;
				end
			end else if (cmd.shift_out) begin
				key_q[i] <= key_q[Nxt];
				id_q[i]  <= id_q[Nxt];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.shift_in) begin
			count_d = count_q + CW'(1);
		end else if (cmd.shift_out) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.head_id     <= cmd.head_load ? id_q[0] : '0;
			rsp_q.head_key    <= cmd.head_load ? key_q[0] : '0;
			rsp_q.head_valid  <= cmd.head_load;
			rsp_q.queue_empty <= (count_d == '0);
			rsp_q.status      <= cmd.status;
		end
	end

	assign stat.op    = op_q;
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rsp_data   = rsp_q;

endmodule

>>> rtl/sorted_priority_queue.sv
// channel  role    payload                              handshake
// req      sink    opcode, entry_key, entry_id          valid & ready
// rsp      source  head_id, head_key, head_valid,       valid & ready
//                  queue_empty, status
// one request in flight: compared against the occupied cells when accepted,
// then shifted with its result registered in exec once the result slot is free;
// the registered compare vector sits ahead of the shift step
// a waiting result does not block the next request; a second one waits in exec
// until the result register is taken
// reset clears the entry count and control state, cell contents are left as is
// depends on spq_pkg, spq_if, spq_ctrl, spq_dp
module sorted_priority_queue (
	input logic            clk,
	input logic            arst_n,
	spq_req_if.sink        req,
	spq_rsp_if.source      rsp
);

	spq_pkg::ctrl_cmd_t cmd;
	spq_pkg::dp_stat_t  stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp.data)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp.valid)
		else $error("executed transaction produced no result");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_in |-> !stat.full && !cmd.shift_out)
		else $error("insert shift into a full array");

	a_head_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.head_valid |-> rsp.data.status == spq_pkg::ST_OK)
		else $error("head reported with error status");

endmodule
